/* hw/rtl/pfx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfx_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_BADCH = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } pfx_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } pfx_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  // Keeps only the first error of an expression.
  function automatic status_t note_err(input status_t cur, input logic hit,
                                       input status_t code);
    return (hit && (cur == ST_OK)) ? code : cur;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfx_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfx_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pfx_pkg::DATA_W-1:0] dividend,
  input  wire logic [pfx_pkg::DATA_W-1:0] divisor,
  output logic                           done,
  output logic [pfx_pkg::DATA_W-1:0]     quotient
);
  import pfx_pkg::*;

  localparam int DCNT_W = $clog2(DATA_W);
  localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(DATA_W - 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dmag_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  assign mag_a   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_b   = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dmag_r};

  // One quotient bit per cycle, restoring on unsigned magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= mag_a;
      dmag_r <= mag_b;
      neg_r  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

`default_nettype wire

/* hw/rtl/postfix_expression_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Postfix evaluator: one ASCII character per input beat; digits build a number,
// + - * / combine the two top operands of a 16-entry stack, and the beat flagged
// last produces one output beat with the stack top and the first error seen.
// The block takes one character at a time and drops in_ready while it works.
// A digit without last is taken in the idle state. Any other character goes
// through a flush state, an operator then through two stack reads through the
// registered RAM port, execute and write back, and a divide by a nonzero value
// waits for the iterative divider, which produces one quotient bit per cycle.
// The last character reads the stack top and loads the output register, which
// lets the next expression start while the result beat is still waiting.
module postfix_expression_evaluator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pfx_pkg::pfx_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pfx_pkg::pfx_out_t      out_data
);
  import pfx_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_RDY, S_RDX, S_EXEC, S_DIVW, S_PUSH, S_TOP, S_TOPW, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              active_r, active_nxt;
  status_t           err_r, err_nxt;
  logic [7:0]        op_r, op_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  pfx_out_t          out_r, out_nxt;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic              flush_ovf;
  logic              flush_push;
  logic [CNT_W-1:0]  cnt_after;
  logic              in_fire;
  state_t            after_st;

  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign after_st = last_r ? S_TOP : S_IDLE;

  assign flush_ovf  = active_r && (count_r == CNT_W'(STACK_DEPTH));
  assign flush_push = active_r && !flush_ovf;
  assign cnt_after  = count_r + CNT_W'(flush_push);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    active_nxt    = active_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    y_nxt         = y_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_addr       = ADDR_W'(count_r - 1'b1);
    wr_en         = 1'b0;
    wr_addr       = count_r[ADDR_W-1:0];
    wr_data       = res_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_data.char_code;
          last_nxt = in_data.last;
          if (is_digit(in_data.char_code)) begin
            acc_nxt    = (acc_r << 3) + (acc_r << 1)
                         + DATA_W'(in_data.char_code - CH_ZERO);
            active_nxt = 1'b1;
            state_nxt  = in_data.last ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // Close an open digit run first, then act on the character.
        wr_en      = flush_push;
        wr_data    = acc_r;
        count_nxt  = cnt_after;
        acc_nxt    = '0;
        active_nxt = 1'b0;
        err_nxt    = note_err(err_r, flush_ovf, ST_OVER);
        if (is_oper(op_r)) begin
          if (cnt_after < CNT_W'(2)) begin
            err_nxt   = note_err(err_nxt, 1'b1, ST_UNDER);
            state_nxt = after_st;
          end else begin
            state_nxt = S_RDY;
          end
        end else begin
          err_nxt   = note_err(err_nxt, !is_digit(op_r) && (op_r != CH_SPACE), ST_BADCH);
          state_nxt = after_st;
        end
      end
      S_RDY: begin
        state_nxt = S_RDX;
      end
      S_RDX: begin
        y_nxt     = rd_data_r;
        rd_addr   = ADDR_W'(count_r - 2'd2);
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        count_nxt = count_r - 2'd2;
        state_nxt = S_PUSH;
        if (op_r == CH_PLUS) begin
          res_nxt = rd_data_r + y_r;
        end else if (op_r == CH_MINUS) begin
          res_nxt = rd_data_r - y_r;
        end else if (op_r == CH_STAR) begin
          res_nxt = rd_data_r * y_r;
        end else if (y_r == '0) begin
          err_nxt = note_err(err_r, 1'b1, ST_DIVZ);
          res_nxt = '0;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // Two entries were just popped, so there is always room here.
        wr_en     = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = after_st;
      end
      S_TOP: begin
        if (count_r == '0) begin
          res_nxt   = '0;
          err_nxt   = note_err(err_r, 1'b1, ST_UNDER);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_TOPW;
        end
      end
      S_TOPW: begin
        res_nxt   = rd_data_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_nxt.value  = res_r;
          out_nxt.status = err_r;
          count_nxt      = '0;
          acc_nxt        = '0;
          active_nxt     = 1'b0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      acc_r       <= '0;
      active_r    <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      active_r    <= active_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    last_r <= last_nxt;
    y_r    <= y_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // Operand stack, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (y_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("operand stack count beyond depth");

  a_exec_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (count_r >= CNT_W'(2)))
    else $error("operator executed with fewer than two operands");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((count_r == '0) && !active_r && (err_r == ST_OK)))
    else $error("state not cleared when a result was loaded");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import pfx_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // Tracks the operand stack of the expression in flight and keeps the results
  // that the block still owes, oldest first.
  class rpn_scoreboard;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       depth;
    logic [DATA_W-1:0] digits_acc;
    bit                in_number;
    status_t           first_err;
    pfx_out_t          pending_results[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       error_results;

    function new();
      clear();
      mismatches    = 0;
      results_seen  = 0;
      error_results = 0;
    endfunction

    function void clear();
      depth      = 0;
      digits_acc = '0;
      in_number  = 1'b0;
      first_err  = ST_OK;
    endfunction

    function void flag(status_t code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    function void push(logic [DATA_W-1:0] v);
      if (depth >= STACK_DEPTH) flag(ST_OVER);
      else begin
        operands[depth] = v;
        depth++;
      end
    endfunction

    function void close_number();
      if (in_number) begin
        push(digits_acc);
        digits_acc = '0;
        in_number  = 1'b0;
      end
    endfunction

    function void note_beat(pfx_in_t b);
      logic [7:0]        c;
      logic [DATA_W-1:0] x, y, r;
      longint            q;
      pfx_out_t          res;
      c = b.char_code;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        digits_acc = digits_acc * 10 + (c - CH_ZERO);
        in_number  = 1'b1;
      end else begin
        close_number();
        if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
          // Too few operands leaves the stack as it was.
          if (depth < 2) flag(ST_UNDER);
          else begin
            y = operands[depth-1];
            x = operands[depth-2];
            depth -= 2;
            case (c)
              CH_PLUS:  r = x + y;
              CH_MINUS: r = x - y;
              CH_STAR:  r = x * y;
              default: begin
                if (y == '0) begin
                  flag(ST_DIVZ);
                  r = '0;
                end else begin
                  // Wide division keeps the most negative value over -1 defined.
                  q = longint'($signed(x)) / longint'($signed(y));
                  r = q[DATA_W-1:0];
                end
              end
            endcase
            push(r);
          end
        end else if (c != CH_SPACE) begin
          flag(ST_BADCH);
        end
      end
      if (!b.last) return;
      close_number();
      res.status = first_err;
      res.value  = '0;
      if (depth > 0) res.value = operands[depth-1];
      else if (res.status == ST_OK) res.status = ST_UNDER;
      pending_results.push_back(res);
      clear();
    endfunction

    function void check_beat(pfx_out_t got);
      pfx_out_t want;
      results_seen++;
      if (got.status != ST_OK) error_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected: value %0d status %0d",
                 $time, got.value, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value) begin
        mismatches++;
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, want.value, got.value);
      end
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pfx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pfx_out_t out_data;

  rpn_scoreboard sb = new();
  logic [7:0]    expr_chars[$];
  int unsigned   chars_sent = 0;
  int unsigned   exprs_sent = 0;
  int unsigned   cycle_count = 0;
  bit            idles_on = 1'b1;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;

  postfix_expression_evaluator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] any_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  // Mostly short numbers, with zeros for the divider, the most negative value,
  // and runs long enough to wrap the accumulator.
  task automatic add_number();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 7) add_text("0");
    else if (kind < 12) add_text("2147483648");
    else begin
      len = (kind < 60) ? 1 : (kind < 90) ? $urandom_range(2, 4) : $urandom_range(9, 12);
      repeat (len) expr_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic gen_wellformed();
    int stack_est;
    bit after_num;
    stack_est = 0;
    after_num = 1'b0;
    repeat ($urandom_range(1, 8)) begin
      if (stack_est < 2 || (stack_est < 12 && $urandom_range(1) == 1)) begin
        if (after_num) repeat ($urandom_range(1, 2)) expr_chars.push_back(CH_SPACE);
        add_number();
        stack_est++;
        after_num = 1'b1;
      end else begin
        if ($urandom_range(3) == 0) expr_chars.push_back(CH_SPACE);
        expr_chars.push_back(any_op());
        stack_est--;
        after_num = 1'b0;
      end
    end
    while (stack_est > 1 && $urandom_range(4) != 0) begin
      expr_chars.push_back(any_op());
      stack_est--;
    end
    if ($urandom_range(4) == 0) expr_chars.push_back(CH_SPACE);
  endtask

  // The handshake is sampled at the falling edge, where it is stable for the
  // rising edge that follows.
  task automatic send_beat(input logic [7:0] c, input logic l);
    bit taken;
    if (idles_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_code: c, last: l};
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_beat(in_data);
    chars_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_chars[i]) send_beat(expr_chars[i], i == expr_chars.size() - 1);
    expr_chars.delete();
    exprs_sent++;
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    int       hold_left;
    bit       took;
    pfx_out_t got;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      took = out_valid && out_ready;
      got  = out_data;
      @(posedge clk);
      if (took) sb.check_beat(got);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idles_on && $urandom_range(99) < 9);
      end
    end
  end

  initial begin
    int pick;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operator on an empty stack.
    add_text("+");
    send_expr();
    // Invalid characters at both ends of the code range; the first one closes a number.
    add_text("9");
    expr_chars.push_back(8'h00);
    send_expr();
    expr_chars.push_back(8'hFF);
    send_expr();
    // Divide by zero stays the reported error when an underflow follows.
    add_text("9 0/+");
    send_expr();
    // Negative difference, division toward zero, then a product.
    add_text("3 10-2/6*");
    send_expr();
    // Trailing number closed by the end of the expression.
    add_text("4 5+ 12");
    send_expr();

    while (chars_sent < 540) begin
      if (!hold_done && chars_sent > 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      idles_on = !(chars_sent >= 300 && chars_sent < 420);
      pick = $urandom_range(99);
      if (pick < 55) gen_wellformed();
      else if (pick < 65) begin
        // Deep stack to run up to or past its capacity.
        for (int i = 0; i < $urandom_range(15, 20); i++) begin
          if (i > 0) expr_chars.push_back(CH_SPACE);
          add_number();
        end
        repeat ($urandom_range(0, 3)) expr_chars.push_back(any_op());
      end else if (pick < 72) begin
        add_text("2147483648 0 1-");
        expr_chars.push_back(($urandom_range(1) == 0) ? CH_SLASH : CH_STAR);
      end else if (pick < 85) begin
        gen_wellformed();
        k = $urandom_range(expr_chars.size() - 1);
        expr_chars[k] = ($urandom_range(1) == 0) ? any_op() : 8'($urandom_range(255));
      end else begin
        repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(255)));
      end
      send_expr();
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Evaluated %0d expressions from %0d characters, with overflow, divide by zero,",
             exprs_sent, chars_sent);
    $display("underflow and invalid input mixed in: %0d results checked, %0d with an error status.",
             sb.results_seen, sb.error_results);
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
